// File: rtl/histogram_equalizer_core_defines.svh
// assertion macros shared by the histogram equalizer rtl
`ifndef HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/histeq_pkg.sv
// shared constants, op codes and types for the histogram equalizer
package histeq_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 8;
    localparam int OP_W        = 2;
    localparam int LEVEL_W     = 8;
    localparam int NUM_BINS    = 256;
    localparam int TOT_W       = 2 * CFG_W;
    localparam int MUL_CNT_W   = 4;
    localparam int STEP_CNT_W  = 3;

    localparam logic [PIX_W-1:0] BIN_LAST = PIX_W'(NUM_BINS - 1);

    // item op codes
    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // divider status toward the sequencer
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } t_div_stat;

endpackage

// File: rtl/histeq_div.sv
// bit-serial divider giving an 8-bit quotient saturated at its maximum
module histeq_div
    import histeq_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat
);

    localparam int W = (NUM_W > DEN_W + LEVEL_W) ? NUM_W : DEN_W + LEVEL_W;

    logic                  r_busy;
    logic                  r_chk;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [W-1:0]          r_rem;
    logic [W-1:0]          r_dsh;
    logic [LEVEL_W-1:0]    r_q;

    logic                  sat;
    logic                  ge;

    // quotient would exceed 8 bits (also covers a zero divisor)
    assign sat = r_rem >= {r_dsh[W-2:0], 1'b0};
    assign ge  = r_rem >= r_dsh;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
            end else if (r_chk) begin
                r_chk <= 1'b0;
                if (sat) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= W'(i_num);
            r_dsh <= W'(i_den) << (LEVEL_W - 1);
            r_cnt <= STEP_CNT_W'(LEVEL_W - 1);
        end else if (r_chk) begin
            if (sat) begin
                r_q <= '1;
            end
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[LEVEL_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;

endmodule

// File: rtl/histogram_equalizer_core.sv
// top level of the two-pass 8-bit grayscale histogram equalizer
//
// Count items read their bin, then write back a saturating increment; clear and
// unused items finish in the idle state, and a map item against a built table reads
// the table memory port. The first map item after any count or clear
// first builds the table: a shift-add multiply for the pixel total, then per
// bin a bin read, the running sum, and the bit-serial divider producing one
// quotient bit a cycle, cut short for a bin whose level saturates at 255. One
// item is worked on at a time; a finished result waits in the output register
// while the next item is taken.
`include "histogram_equalizer_core_defines.svh"

module histogram_equalizer_core
    import histeq_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_op,
    input  logic [PIX_W-1:0]     i_pixel_in,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LEVEL_W-1:0]   o_pixel_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int NUM_W = COUNT_BITS + LEVEL_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CNT_WR   = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_BIN_RD   = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_MAP_RD   = 3'd6;
    localparam logic [2:0] S_MAP_OUT  = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [PIX_W-1:0]      r_pix, n_pix;
    logic [PIX_W-1:0]      r_bin, n_bin;
    logic [COUNT_BITS-1:0] r_sum, n_sum;
    logic                  r_tbl_vld, n_tbl_vld;
    logic [NUM_BINS-1:0]   r_bin_vld, n_bin_vld;
    logic [CFG_W-1:0]      r_width, r_height;
    logic [TOT_W-1:0]      r_mul_acc, n_mul_acc;
    logic [TOT_W-1:0]      r_mul_a, n_mul_a;
    logic [CFG_W-1:0]      r_mul_b, n_mul_b;
    logic [MUL_CNT_W-1:0]  r_mul_cnt, n_mul_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]    r_out_pix, n_out_pix;

    // memories and their read registers
    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [LEVEL_W-1:0]    map_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_bin_q;
    logic [LEVEL_W-1:0]    r_map_q;

    logic                  bin_re, bin_we;
    logic [PIX_W-1:0]      bin_raddr;
    logic [COUNT_BITS-1:0] bin_wdata;
    logic                  map_re, map_we;
    logic [PIX_W-1:0]      map_raddr;

    logic                  in_xfer;
    logic [PIX_W-1:0]      cur_addr;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS:0]   sum_wide;
    logic [NUM_W-1:0]      div_num;
    logic                  div_start;
    t_div_stat             div_stat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign in_xfer     = i_in_valid && o_in_ready;

    // stored bin count, reading zero where the bin was cleared
    assign cur_addr = (r_state == S_CNT_WR) ? r_pix : r_bin;
    assign cur_cnt  = r_bin_vld[cur_addr] ? r_bin_q : '0;
    assign sum_wide = {1'b0, r_sum} + {1'b0, cur_cnt};

    // 255 * running sum
    assign div_num   = {r_sum, {LEVEL_W{1'b0}}} - NUM_W'(r_sum);
    assign div_start = (r_state == S_DIV_GO);

    histeq_div #(
        .NUM_W (NUM_W),
        .DEN_W (TOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_mul_acc),
        .o_stat  (div_stat)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pix       = r_pix;
        n_bin       = r_bin;
        n_sum       = r_sum;
        n_tbl_vld   = r_tbl_vld;
        n_bin_vld   = r_bin_vld;
        n_mul_acc   = r_mul_acc;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_mul_cnt   = r_mul_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pix   = r_out_pix;
        bin_re      = 1'b0;
        bin_raddr   = r_bin;
        bin_we      = 1'b0;
        bin_wdata   = cur_cnt + 1'b1;
        map_re      = 1'b0;
        map_raddr   = r_pix;
        map_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_pix = i_pixel_in;
                    case (i_op)
                        OP_COUNT: begin
                            bin_re    = 1'b1;
                            bin_raddr = i_pixel_in;
                            n_tbl_vld = 1'b0;
                            n_state   = S_CNT_WR;
                        end
                        OP_MAP: begin
                            if (r_tbl_vld) begin
                                map_re    = 1'b1;
                                map_raddr = i_pixel_in;
                                n_state   = S_MAP_OUT;
                            end else begin
                                n_mul_acc = '0;
                                n_mul_a   = TOT_W'(r_width);
                                n_mul_b   = r_height;
                                n_mul_cnt = MUL_CNT_W'(CFG_W - 1);
                                n_state   = S_MUL;
                            end
                        end
                        OP_CLEAR: begin
                            n_bin_vld = '0;
                            n_tbl_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CNT_WR: begin
                // saturating increment
                if (cur_cnt != '1) begin
                    bin_we           = 1'b1;
                    n_bin_vld[r_pix] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_MUL: begin
                // shift-add, one multiplier bit per cycle
                if (r_mul_b[0]) begin
                    n_mul_acc = r_mul_acc + r_mul_a;
                end
                n_mul_a   = r_mul_a << 1;
                n_mul_b   = r_mul_b >> 1;
                n_mul_cnt = r_mul_cnt - 1'b1;
                if (r_mul_cnt == '0) begin
                    n_bin     = '0;
                    n_sum     = '0;
                    bin_re    = 1'b1;
                    bin_raddr = '0;
                    n_state   = S_BIN_RD;
                end
            end
            S_BIN_RD: begin
                // running sum, saturating
                n_sum   = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    map_we = 1'b1;
                    if (r_bin == BIN_LAST) begin
                        n_tbl_vld = 1'b1;
                        n_state   = S_MAP_RD;
                    end else begin
                        n_bin     = r_bin + 1'b1;
                        bin_re    = 1'b1;
                        bin_raddr = r_bin + 1'b1;
                        n_state   = S_BIN_RD;
                    end
                end
            end
            S_MAP_RD: begin
                map_re  = 1'b1;
                n_state = S_MAP_OUT;
            end
            S_MAP_OUT: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_map_q;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tbl_vld   <= 1'b0;
            r_bin_vld   <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_width     <= CFG_W'(1);
            r_height    <= CFG_W'(1);
        end else begin
            r_state     <= n_state;
            r_tbl_vld   <= n_tbl_vld;
            r_bin_vld   <= n_bin_vld;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            // configuration transfer
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pix     <= n_pix;
        r_bin     <= n_bin;
        r_mul_acc <= n_mul_acc;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        r_mul_cnt <= n_mul_cnt;
        r_out_pix <= n_out_pix;
    end

    // bin count memory
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            bin_mem[r_pix] <= bin_wdata;
        end
        if (bin_re) begin
            r_bin_q <= bin_mem[bin_raddr];
        end
    end

    // equalization table memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[r_bin] <= div_stat.quot;
        end
        if (map_re) begin
            r_map_q <= map_mem[map_raddr];
        end
    end

    // divider answers only while the sequencer waits on it
    `HEQ_ASSERT_NOW(a_div_done_wait, div_stat.done, r_state == S_DIV_WAIT, "divider done out of turn")
    // results only come from a built table
    `HEQ_ASSERT_NOW(a_map_tbl_vld, r_state == S_MAP_OUT, r_tbl_vld, "map result without a table")
    // a pending result is never overwritten
    `HEQ_ASSERT_NEXT(a_out_hold, r_state == S_MAP_OUT && r_out_valid && !i_out_ready,
                     r_state == S_MAP_OUT && $stable(r_out_pix), "pending result overwritten")

endmodule

// File: test/histogram_equalizer_core_test.sv
// self-checking testbench for the histogram equalizer core
module histogram_equalizer_core_test;
    import histeq_pkg::*;

    localparam int COUNT_W = 24;
    localparam longint unsigned BIN_MAX = (64'd1 << COUNT_W) - 1;
    localparam longint unsigned LEVEL_MAX = 255;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1040;

    // op code that the core ignores and register indexes with no register behind them
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op;
    logic [PIX_W-1:0]     i_pixel_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [LEVEL_W-1:0]   o_pixel_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    histogram_equalizer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirror of the equalizer state
    logic [COUNT_W-1:0] hist_bins [NUM_BINS];
    logic [LEVEL_W-1:0] level_table [NUM_BINS];
    bit                 table_built;
    logic [CFG_W-1:0]   frame_w;
    logic [CFG_W-1:0]   frame_h;

    // equalized levels owed by the core, oldest first
    logic [LEVEL_W-1:0] levels_pending [$];
    logic [LEVEL_W-1:0] level_want;
    int                 error_count;

    // sender pacing
    int burst_left;
    int random_items;

    // directed stimulus rows
    typedef struct {
        bit                   is_write;
        logic [OP_W-1:0]      op;
        logic [PIX_W-1:0]     pix;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
        bit                   typed;
        logic [LEVEL_W-1:0]   level;
    } t_script_row;

    t_script_row script [$];

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    // cumulative histogram scaled to 0..255, bin 0 included
    function automatic void rebuild_level_table();
        longint unsigned total;
        longint unsigned acc;
        longint unsigned lvl;
        total = 64'(frame_w) * 64'(frame_h);
        acc = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
            acc += 64'(hist_bins[b]);
            if (acc > BIN_MAX) begin
                acc = BIN_MAX;
            end
            if (total == 0) begin
                lvl = LEVEL_MAX;
            end else begin
                lvl = (LEVEL_MAX * acc) / total;
                if (lvl > LEVEL_MAX) begin
                    lvl = LEVEL_MAX;
                end
            end
            level_table[b] = LEVEL_W'(lvl);
        end
        table_built = 1'b1;
    endfunction

    // apply one accepted item, return the equalized level if the item gives one
    function automatic void track_pixel_item(input logic [OP_W-1:0] op,
                                             input logic [PIX_W-1:0] pix,
                                             output bit gives,
                                             output logic [LEVEL_W-1:0] lvl);
        gives = 1'b0;
        lvl = '0;
        case (op)
            OP_COUNT: begin
                if (hist_bins[pix] != {COUNT_W{1'b1}}) begin
                    hist_bins[pix] = hist_bins[pix] + 1'b1;
                end
                table_built = 1'b0;
            end
            OP_MAP: begin
                if (!table_built) begin
                    rebuild_level_table();
                end
                lvl = level_table[pix];
                gives = 1'b1;
            end
            OP_CLEAR: begin
                foreach (hist_bins[b]) begin
                    hist_bins[b] = '0;
                end
                table_built = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                                     input bit typed = 1'b0,
                                     input logic [LEVEL_W-1:0] level = '0);
        t_script_row row;
        row = '{1'b0, op, pix, '0, '0, typed, level};
        script.insert(script.size(), row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        t_script_row row;
        row = '{1'b1, OP_COUNT, '0, idx, data, 1'b0, '0};
        script.insert(script.size(), row);
    endfunction

    // hold the item until its transfer, then predict
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                             input bit typed, input logic [LEVEL_W-1:0] typed_level);
        bit gives;
        logic [LEVEL_W-1:0] lvl;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        track_pixel_item(op, pix, gives, lvl);
        if (gives) begin
            levels_pending.insert(levels_pending.size(), typed ? typed_level : lvl);
        end
    endtask

    // bursts of random length separated by random gaps
    task automatic feed_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                             input bit typed = 1'b0,
                             input logic [LEVEL_W-1:0] typed_level = '0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(op, pix, typed, typed_level);
    endtask

    // stop sending and wait until every owed level has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (levels_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = data;
            REG_FRAME_HEIGHT: frame_h = data;
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // clear, count, map or stray item in the random part
    task automatic random_feed(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix);
        if ($urandom_range(0, 19) == 0) begin
            feed_item(OP_UNUSED, PIX_W'($urandom));
        end
        feed_item(op, pix);
        random_items++;
    endtask

    function automatic void build_script();
        // reset frame is 1x1: empty histogram maps everything to 0
        add_item(OP_MAP, 8'd0, 1'b1, 8'd0);
        add_item(OP_MAP, 8'd255, 1'b1, 8'd0);
        // one pixel in bin 0 fills the whole frame
        add_item(OP_COUNT, 8'd0);
        add_item(OP_MAP, 8'd0, 1'b1, 8'd255);
        add_item(OP_MAP, 8'd255, 1'b1, 8'd255);
        // more pixels than the frame holds, level saturates
        add_item(OP_COUNT, 8'd255);
        add_item(OP_COUNT, 8'd128);
        add_item(OP_MAP, 8'd128, 1'b1, 8'd255);
        // unused op leaves the built table alone
        add_item(OP_UNUSED, 8'd77);
        add_item(OP_MAP, 8'd0, 1'b1, 8'd255);
        // clear empties every bin
        add_item(OP_CLEAR, 8'd0);
        add_item(OP_MAP, 8'd200, 1'b1, 8'd0);
        add_item(OP_MAP, 8'd0, 1'b1, 8'd0);
        // zero width: built table is kept until the next build, then all 255
        add_write(REG_FRAME_WIDTH, 13'd0);
        add_item(OP_MAP, 8'd5, 1'b1, 8'd0);
        add_item(OP_COUNT, 8'd5);
        add_item(OP_MAP, 8'd5, 1'b1, 8'd255);
        // largest frame, spare register indexes do nothing
        add_write(REG_FRAME_WIDTH, 13'h1fff);
        add_write(REG_FRAME_HEIGHT, 13'h1fff);
        add_write(REG_SPARE_2, 13'h1fff);
        add_write(REG_SPARE_3, 13'd0);
        add_item(OP_COUNT, 8'd255);
        add_item(OP_MAP, 8'd255);
        // 1x2 frame with three pixels
        add_write(REG_FRAME_WIDTH, 13'd1);
        add_write(REG_FRAME_HEIGHT, 13'd2);
        add_item(OP_COUNT, 8'd10);
        add_item(OP_MAP, 8'd10, 1'b1, 8'd255);
        add_item(OP_MAP, 8'd4, 1'b1, 8'd0);
        add_item(OP_MAP, 8'd7);
        add_item(OP_MAP, 8'd128);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #12_000_000;
        $display("histogram_equalizer_core_test NOT OK");
        $finish;
    end

    // result side: ready follows its own slowly changing duty cycle
    initial begin
        int mode_left;
        int ready_pct;
        mode_left = 0;
        ready_pct = 100;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 70;
                    2:       ready_pct = 35;
                    default: ready_pct = 8;
                endcase
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // check each result transfer against the oldest owed level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (levels_pending.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing owed", o_pixel_out));
            end else begin
                level_want = levels_pending.pop_front();
                if (o_pixel_out !== level_want) begin
                    report_mismatch($sformatf("pixel_out %0d, want %0d",
                                              o_pixel_out, level_want));
                end
            end
        end
    end

    // stimulus
    initial begin
        int n_counts;
        int n_maps;
        int base;
        int spread;
        int mode;
        bit extra_count;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        error_count = 0;
        burst_left = 0;
        random_items = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_COUNT;
        i_pixel_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data <= '0;
        foreach (hist_bins[b]) begin
            hist_bins[b] = '0;
            level_table[b] = '0;
        end
        table_built = 1'b0;
        frame_w = 13'd1;
        frame_h = 13'd1;
        build_script();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (script[i]) begin
            if (script[i].is_write) begin
                write_register(script[i].reg_idx, script[i].reg_data);
            end else begin
                feed_item(script[i].op, script[i].pix, script[i].typed, script[i].level);
            end
        end

        // random part: frames of an optional clear, counts, then maps
        while (random_items < RANDOM_ITEMS) begin
            n_counts = ($urandom_range(0, 9) == 0) ? 0 :
                       ($urandom_range(0, 4) == 0) ? $urandom_range(41, 80) :
                       $urandom_range(4, 40);
            n_maps = $urandom_range(4, 25);

            // frame size, sometimes left alone
            if ($urandom_range(0, 2) == 0) begin
                mode = $urandom_range(0, 9);
                if (mode <= 3) begin
                    w_val = CFG_W'((n_counts == 0) ? 1 : n_counts);
                    h_val = 13'd1;
                end else if (mode <= 6) begin
                    w_val = CFG_W'($urandom_range(1, 16));
                    h_val = CFG_W'($urandom_range(1, 8));
                end else if (mode == 7) begin
                    w_val = $urandom_range(0, 1) ? 13'd0 : CFG_W'($urandom_range(1, 8191));
                    h_val = (w_val == 0) ? CFG_W'($urandom_range(0, 8191)) : 13'd0;
                end else begin
                    w_val = CFG_W'($urandom_range(0, 8191));
                    h_val = CFG_W'($urandom_range(0, 8191));
                end
                if ($urandom_range(0, 1)) begin
                    write_register(REG_FRAME_WIDTH, w_val);
                    write_register(REG_FRAME_HEIGHT, h_val);
                end else begin
                    write_register(REG_FRAME_HEIGHT, h_val);
                    write_register(REG_FRAME_WIDTH, w_val);
                end
                if ($urandom_range(0, 3) == 0) begin
                    write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                                   CFG_W'($urandom_range(0, 8191)));
                end
            end

            if ($urandom_range(0, 9) < 7) begin
                random_feed(OP_CLEAR, PIX_W'($urandom));
            end

            // pixels drawn from a window of random width
            base = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
                0:       spread = 3;
                1:       spread = 15;
                2:       spread = 63;
                default: spread = 255;
            endcase
            repeat (n_counts) begin
                random_feed(OP_COUNT, PIX_W'(base + $urandom_range(0, spread)));
            end

            // maps, at most one stray count forcing a second build
            extra_count = 1'b0;
            repeat (n_maps) begin
                if (!extra_count && $urandom_range(0, 29) == 0) begin
                    extra_count = 1'b1;
                    random_feed(OP_COUNT, PIX_W'($urandom));
                end
                random_feed(OP_MAP, PIX_W'($urandom));
            end

            // now and then hold off until everything owed is back
            if ($urandom_range(0, 4) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("histogram_equalizer_core_test OK");
        end else begin
            $display("histogram_equalizer_core_test NOT OK");
        end
        $finish;
    end

endmodule
